FILE: design/digital_net_gray_code_generator_defines.svh
// ----------------------------------------------------------------------------
// Digital net Gray-code generator: assertion macros
// Shared property wrappers for the generator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DIGITAL_NET_GRAY_CODE_GENERATOR_DEFINES_SVH
`define DIGITAL_NET_GRAY_CODE_GENERATOR_DEFINES_SVH

// Same-cycle implication, gated off while reset is high.
`define DNGC_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off while reset is high.
`define DNGC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dngc_pkg.sv
// ----------------------------------------------------------------------------
// Digital net Gray-code generator package
// Sizes, function and register codes, and the transaction payload types.
// ----------------------------------------------------------------------------
package dngc_pkg;

  localparam int DIMS        = 8;
  localparam int MAX_COLUMNS = 64;
  localparam int OUT_DIMS    = (DIMS < 8) ? DIMS : 8;
  localparam int DIM_W       = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int MEM_DEPTH   = DIMS * MAX_COLUMNS;
  localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int WORD_W      = 64;
  localparam int LIMIT_W     = 7;

  typedef enum logic [1:0] {
    FUNC_LOAD_COL   = 2'd0,
    FUNC_LOAD_SHIFT = 2'd1,
    FUNC_SEED       = 2'd2,
    FUNC_NEXT       = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_COLUMN_COUNT = 2'd0,
    CFG_SHIFT_ENABLE = 2'd1,
    CFG_LEFT_SHIFT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    func_t               func;
    logic [2:0]          dim;
    logic [5:0]          column;
    logic [WORD_W-1:0]   data;
    logic [WORD_W-1:0]   start_index;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   position;
    logic [2:0]          out_dim;
    logic [WORD_W-1:0]   value;
    logic                overrun;
    logic                last;
  } result_t;

endpackage

FILE: design/digital_net_gray_code_generator.sv
// ----------------------------------------------------------------------------
// Digital net Gray-code generator
// Base-2 digital net (Sobol-style) point generator walking indices in Gray
// order, with per-dimension digital shift and optional left shift.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  item     | item_valid / item_stall  | item   (func, dim, column, data,
//           |                          |         start_index)
//  result   | result_valid/result_stall| result (position, out_dim, value,
//           |                          |         overrun, last)
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  Loads complete in the idle state. A next transaction makes one column read
//  per dimension on the matrix RAM port before its first result; a seed makes
//  one RAM read per column and dimension, folded by one shared XOR
//  accumulator. An overrun skips the sweep. Results then leave one per cycle
//  while result_stall is low, OUT_DIMS of them.
//  Reset is synchronous; the matrix RAM is not cleared.
//  A stalled result holds the block in its emit phase; item_stall stays high
//  until the last result is in the output register.
// ----------------------------------------------------------------------------
`include "digital_net_gray_code_generator_defines.svh"

module digital_net_gray_code_generator import dngc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  item_t         item,
  output logic          result_valid,
  input  logic          result_stall,
  output result_t       result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [6:0]    cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SEED_CHK = 6'b000010,
    S_NEXT_CHK = 6'b000100,
    S_SWEEP    = 6'b001000,
    S_DRAIN    = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic [LIMIT_W-1:0] column_count;
  logic               shift_enable;
  logic [5:0]         left_shift;

  // Point state
  logic [WORD_W-1:0]  current_index;
  logic [WORD_W-1:0]  point_words [DIMS];
  logic [WORD_W-1:0]  digital_shifts [DIMS];

  // Working registers for the item in flight
  logic [WORD_W-1:0]  pend_index;
  logic [WORD_W-1:0]  gray_word;
  logic               next_mode;
  logic [COL_W-1:0]   next_col;
  logic               ovr_flag;
  logic [DIM_W-1:0]   sw_dim;
  logic [COL_W-1:0]   sw_col;
  logic [DIM_W-1:0]   e_cnt;

  // Matrix RAM and its read pipeline
  logic [WORD_W-1:0]  mem [MEM_DEPTH];
  logic [WORD_W-1:0]  rd_data;
  logic               rd_vld;
  logic [DIM_W-1:0]   rd_dim;
  logic [COL_W-1:0]   rd_col;
  logic               rd_last;
  logic [WORD_W-1:0]  acc;
  logic [WORD_W-1:0]  acc_x;

  logic               item_accept;
  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr;
  logic [MEM_AW-1:0]  mem_raddr;
  logic [COL_W-1:0]   issue_col;
  logic               issue_last_col;
  logic [LIMIT_W-1:0] limit;
  logic [WORD_W-1:0]  low_bit;
  logic [5:0]         low_col;
  logic               result_load;
  logic               emit_last;
  logic [WORD_W-1:0]  emit_word;

  // Configuration port never back-pressures.
  assign cfg_ready = 1'b1;

  // Accept items only between transactions.
  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;

  // Usable column limit: min(column_count, MAX_COLUMNS).
  assign limit = (column_count < LIMIT_W'(MAX_COLUMNS)) ? column_count
                                                       : LIMIT_W'(MAX_COLUMNS);

  // Column loads outside the matrix are dropped.
  assign mem_we = item_accept && (item.func == FUNC_LOAD_COL) &&
                  (32'(item.dim) < DIMS) && (32'(item.column) < MAX_COLUMNS);
  assign mem_waddr = MEM_AW'(32'(item.dim) * MAX_COLUMNS + 32'(item.column));

  // Seed sweeps every column of each dimension; next reads one column.
  assign issue_col      = next_mode ? next_col : sw_col;
  assign issue_last_col = next_mode || (32'(sw_col) == MAX_COLUMNS - 1);
  assign mem_raddr      = MEM_AW'(32'(sw_dim) * MAX_COLUMNS + 32'(issue_col));

  // The new index's lowest set bit is where the old index's trailing ones end.
  assign low_bit = pend_index & ~current_index;
  always_comb begin
    low_col = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low_bit[i]) begin
        low_col = low_col | 6'(i);
      end
    end
  end

  // Shared accumulator: fold in the column when its Gray bit is set.
  assign acc_x = acc ^ (gray_word[6'(rd_col)] ? rd_data : '0);

  // Emit path
  assign result_load = (state == S_EMIT) && (!result_valid || !result_stall);
  assign emit_last   = (32'(e_cnt) == OUT_DIMS - 1);
  assign emit_word   = shift_enable ?
                       ((point_words[e_cnt] << left_shift) ^ digital_shifts[e_cnt])
                       : point_words[e_cnt];

  // Matrix RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= item.data;
    end
    rd_data <= mem[mem_raddr];
  end

  // Read pipeline tags travel with the registered RAM data.
  always_ff @(posedge clk) begin
    rd_dim  <= sw_dim;
    rd_col  <= issue_col;
    rd_last <= issue_last_col;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= LIMIT_W'(64);
      shift_enable <= 1'b0;
      left_shift   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMN_COUNT: column_count <= cfg_data;
        CFG_SHIFT_ENABLE: shift_enable <= cfg_data[0];
        CFG_LEFT_SHIFT:   left_shift   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Digital shift loads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIMS; j++) begin
        digital_shifts[j] <= '0;
      end
    end else if (item_accept && (item.func == FUNC_LOAD_SHIFT) &&
                 (32'(item.dim) < DIMS)) begin
      digital_shifts[DIM_W'(item.dim)] <= item.data;
    end
  end

  // Point words: next XORs a column in place, seed rebuilds through acc.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIMS; j++) begin
        point_words[j] <= '0;
      end
      acc <= '0;
    end else if (state == S_SEED_CHK) begin
      acc <= '0;
    end else if (rd_vld) begin
      if (next_mode) begin
        point_words[rd_dim] <= point_words[rd_dim] ^ rd_data;
      end else begin
        acc <= rd_last ? '0 : acc_x;
        if (rd_last) begin
          point_words[rd_dim] <= acc_x;
        end
      end
    end
  end

  // Operand capture for the item in flight
  always_ff @(posedge clk) begin
    if (item_accept) begin
      if (item.func == FUNC_SEED) begin
        pend_index <= item.start_index;
        gray_word  <= item.start_index ^ (item.start_index >> 1);
      end else begin
        pend_index <= current_index + WORD_W'(1);
      end
    end
    if (state == S_NEXT_CHK) begin
      next_col <= COL_W'(low_col);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      current_index <= '0;
      next_mode     <= 1'b0;
      ovr_flag      <= 1'b0;
      sw_dim        <= '0;
      sw_col        <= '0;
      e_cnt         <= '0;
      rd_vld        <= 1'b0;
    end else begin
      rd_vld <= (state == S_SWEEP);
      case (state)
        S_IDLE: begin
          if (item_accept) begin
            case (item.func)
              FUNC_SEED: begin
                next_mode <= 1'b0;
                state     <= S_SEED_CHK;
              end
              FUNC_NEXT: begin
                next_mode <= 1'b1;
                state     <= S_NEXT_CHK;
              end
              default: ;
            endcase
          end
        end
        S_SEED_CHK: begin
          sw_dim <= '0;
          sw_col <= '0;
          e_cnt  <= '0;
          // Any Gray bit at or above the limit: keep the point, flag it.
          if ((gray_word >> limit) != '0) begin
            ovr_flag <= 1'b1;
            state    <= S_EMIT;
          end else begin
            ovr_flag <= 1'b0;
            state    <= S_SWEEP;
          end
        end
        S_NEXT_CHK: begin
          sw_dim <= '0;
          sw_col <= '0;
          e_cnt  <= '0;
          // Index wrap or a column past the limit is an overrun.
          if ((pend_index == '0) || ({1'b0, low_col} >= limit)) begin
            ovr_flag <= 1'b1;
            state    <= S_EMIT;
          end else begin
            ovr_flag <= 1'b0;
            state    <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (issue_last_col) begin
            sw_col <= '0;
            sw_dim <= sw_dim + DIM_W'(1);
            if (32'(sw_dim) == DIMS - 1) begin
              state <= S_DRAIN;
            end
          end else begin
            sw_col <= sw_col + COL_W'(1);
          end
        end
        S_DRAIN: begin
          // Last read folds in this cycle; commit the new index.
          current_index <= pend_index;
          state         <= S_EMIT;
        end
        S_EMIT: begin
          if (result_load) begin
            e_cnt <= e_cnt + DIM_W'(1);
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.position <= current_index ^ (current_index >> 1);
      result.out_dim  <= 3'(e_cnt);
      result.value    <= emit_word;
      result.overrun  <= ovr_flag;
      result.last     <= emit_last;
    end
  end

  // Checks
  `DNGC_ASSERT_IMPL(a_ovr_keeps_index, clk, rst, (state == S_EMIT) && ovr_flag, $stable(current_index), "overrun changed the current index")
  `DNGC_ASSERT_NEXT(a_last_to_idle, clk, rst, result_load && emit_last, state == S_IDLE, "sequencer did not return to idle after the last result")
  `DNGC_ASSERT_NEXT(a_drain_ends_reads, clk, rst, state == S_DRAIN, !rd_vld, "matrix read still in flight after drain")
  `DNGC_ASSERT_NEXT(a_load_stays_idle, clk, rst, item_accept && ((item.func == FUNC_LOAD_COL) || (item.func == FUNC_LOAD_SHIFT)), state == S_IDLE, "load transaction left idle")

endmodule
